// File: hw/rtl/scfr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the sync frame receiver.
// No dependencies; imported by every module of the block except scfr_ram.
`default_nettype none

package scfr_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'd117;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd84;

    // at most this many words leave per frame (word index is 4 bits)
    localparam int MAX_WORDS = 16;

    // configuration register indexes
    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    // frame status codes
    localparam logic STATUS_WORD   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CHECK = 5'b00100,
        S_READ  = 5'b01000,
        S_PUSH  = 5'b10000
    } t_state;

    typedef struct packed {
        logic        frame_status;
        logic [3:0]  word_index;
        logic [31:0] word_value;
        logic        last_of_frame;
    } t_result;

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scfr_ram.sv
// Single-port frame byte memory, registered read data.
// Depends on nothing but its DEPTH parameter.
`default_nettype none

module scfr_ram #(
    parameter int DEPTH = 68
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [7:0]               i_wdata,
    output logic [7:0]                    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/scfr_ctrl.sv
// Sequencer: fills the circular frame store, walks it for CRC and sync scan,
// reads payload words back. Uses scfr_pkg; drives the port of scfr_ram.
`default_nettype none

module scfr_ctrl
    import scfr_pkg::*;
#(
    parameter int FRAME_BYTES   = 68,
    parameter int PAYLOAD_WORDS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic [7:0]                     i_sync_first,
    input  wire logic [7:0]                     i_sync_second,
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output t_result                             o_res,
    output logic                                o_mem_we,
    output logic [$clog2(FRAME_BYTES)-1:0]      o_mem_addr,
    output logic [7:0]                          o_mem_wdata,
    input  wire logic [7:0]                     i_mem_rdata
);

    localparam int AW      = $clog2(FRAME_BYTES);
    localparam int NOUT    = (PAYLOAD_WORDS > MAX_WORDS) ? MAX_WORDS : PAYLOAD_WORDS;
    localparam int WW      = (NOUT > 1) ? $clog2(NOUT) : 1;
    localparam int PAY_END = 2 + 4 * NOUT;
    localparam int LSPAN   = (FRAME_BYTES > PAY_END) ? FRAME_BYTES : PAY_END;
    localparam int LW      = $clog2(LSPAN + 1);

    t_state        r_state;
    logic [AW-1:0] r_count;
    logic [AW-1:0] r_base;
    logic [LW-1:0] r_ptr;
    logic          r_dv;
    logic [AW-1:0] r_didx;
    logic [15:0]   r_crc;
    logic [7:0]    r_prev;
    logic [7:0]    r_last;
    logic          r_found;
    logic [AW-1:0] r_pos;
    logic [WW-1:0] r_word;
    logic [2:0]    r_lane;
    logic [1:0]    r_dlane;
    logic          r_dzero;
    logic [31:0]   r_wval;

    logic          in_acc;
    logic          drop_first;
    logic          drop_second;
    logic          store_we;
    logic [LW-1:0] pay_p;
    logic          pay_iss;
    logic          pay_zero;
    logic          scan_iss;
    logic [AW-1:0] log_addr;
    logic [AW:0]   sum_addr;
    logic [AW-1:0] phys_addr;
    logic          last_word;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign drop_first  = (r_count == '0) && (i_rx_byte != i_sync_first);
    assign drop_second = (r_count == AW'(1)) && (i_rx_byte != i_sync_second);
    assign store_we    = in_acc && !drop_first && !drop_second;

    assign pay_p    = LW'(2) + (LW'(r_word) << 2) + LW'(r_lane[1:0]);
    assign pay_iss  = !r_lane[2];
    assign pay_zero = pay_p >= LW'(FRAME_BYTES);
    assign scan_iss = r_ptr < LW'(FRAME_BYTES);

    assign last_word = (r_word == WW'(NOUT - 1));

    // logical position -> physical entry; the store is a ring starting at r_base
    always_comb begin
        case (r_state)
            S_IDLE:  log_addr = r_count;
            S_SCAN:  log_addr = r_ptr[AW-1:0];
            S_CHECK: log_addr = r_found ? r_pos : AW'(FRAME_BYTES - 1);
            default: log_addr = pay_p[AW-1:0];
        endcase
        sum_addr = {1'b0, r_base} + {1'b0, log_addr};
        if (sum_addr >= (AW+1)'(FRAME_BYTES)) begin
            phys_addr = AW'(sum_addr - (AW+1)'(FRAME_BYTES));
        end else begin
            phys_addr = sum_addr[AW-1:0];
        end
    end

    assign o_mem_we    = store_we;
    assign o_mem_addr  = phys_addr;
    assign o_mem_wdata = i_rx_byte;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '{frame_status: STATUS_REJECT, word_index: 4'd0,
                        word_value: 32'd0, last_of_frame: 1'b1};
        case (r_state)
            S_CHECK: begin
                o_res_valid = (r_crc != 16'd0);
            end
            S_PUSH: begin
                o_res_valid = 1'b1;
                o_res       = '{frame_status: STATUS_WORD, word_index: 4'(r_word),
                                word_value: r_wval, last_of_frame: last_word};
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_base  <= '0;
            r_dv    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && !drop_first) begin
                        if (drop_second) begin
                            r_count <= '0;
                        end else if (r_count == AW'(FRAME_BYTES - 1)) begin
                            r_state <= S_SCAN;
                            r_ptr   <= '0;
                            r_dv    <= 1'b0;
                            r_crc   <= CRC_INIT;
                            r_found <= 1'b0;
                        end else begin
                            r_count <= r_count + AW'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_iss) begin
                        r_ptr <= r_ptr + LW'(1);
                    end
                    r_dv   <= scan_iss;
                    r_didx <= r_ptr[AW-1:0];
                    if (r_dv) begin
                        r_crc  <= crc_byte(r_crc, i_mem_rdata);
                        r_prev <= i_mem_rdata;
                        // first sync pair starting at position 2 or later
                        if (!r_found && (r_didx >= AW'(3)) && (r_prev == i_sync_first) &&
                            (i_mem_rdata == i_sync_second)) begin
                            r_found <= 1'b1;
                            r_pos   <= r_didx - AW'(1);
                        end
                        if (r_didx == AW'(FRAME_BYTES - 1)) begin
                            r_last  <= i_mem_rdata;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_crc == 16'd0) begin
                        r_count <= '0;
                        r_word  <= '0;
                        r_lane  <= '0;
                        r_dv    <= 1'b0;
                        r_state <= S_READ;
                    end else if (i_res_ready) begin
                        r_state <= S_IDLE;
                        if (r_found) begin
                            r_base  <= phys_addr;
                            r_count <= AW'((AW+1)'(FRAME_BYTES) - {1'b0, r_pos});
                        end else if (r_last == i_sync_first) begin
                            // keep the trailing first-sync byte in place
                            r_base  <= phys_addr;
                            r_count <= AW'(1);
                        end else begin
                            r_count <= '0;
                        end
                    end
                end
                S_READ: begin
                    if (pay_iss) begin
                        r_lane <= r_lane + 3'd1;
                    end
                    r_dv    <= pay_iss;
                    r_dlane <= r_lane[1:0];
                    r_dzero <= pay_zero;
                    if (r_dv) begin
                        r_wval <= {(r_dzero ? 8'd0 : i_mem_rdata), r_wval[31:8]};
                        if (r_dlane == 2'd3) begin
                            r_state <= S_PUSH;
                        end
                    end
                end
                S_PUSH: begin
                    if (i_res_ready) begin
                        if (last_word) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_word  <= r_word + WW'(1);
                            r_lane  <= '0;
                            r_dv    <= 1'b0;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sync_crc_frame_receiver.sv
// Top level of the sync frame receiver: config registers, result output register.
// Instantiates scfr_ctrl and scfr_ram; uses scfr_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_rx_byte): one received byte per
//   request. A byte that does not complete a frame is taken in the same cycle it is offered.
//   The byte that completes a frame starts a walk over the stored bytes
//   (one memory read per cycle) for the CRC-16 check and the resync scan.
//   A reject then leaves as one result; a pass leaves as up to 16 words,
//   each read from memory byte by byte and then pushed; o_in_ready is low
//   during that time.
//   Output channel (o_out_valid / i_out_ready): one result register; the next
//   result is loaded as the current one is taken. A stalled receiver holds the
//   sequencer in its check or push step; no result is lost.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets the
//   first sync byte, index 1 the second; write only while idle.
//   Reset (synchronous, active low) empties the frame, clears the output valid and
//   restores sync bytes 117 and 84. The store needs no clearing pass.
`default_nettype none

module sync_crc_frame_receiver
    import scfr_pkg::*;
#(
    parameter int FRAME_BYTES   = 68,
    parameter int PAYLOAD_WORDS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_frame_status,
    output logic [3:0]       o_word_index,
    output logic [31:0]      o_word_value,
    output logic             o_last_of_frame,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int AW = $clog2(FRAME_BYTES);

    logic [7:0]    r_sync_first;
    logic [7:0]    r_sync_second;
    logic          r_out_vld;
    t_result       r_out;

    logic          res_valid;
    logic          slot_free;
    t_result       res;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: begin
                    r_sync_first <= r_sync_first;
                end
            endcase
        end
    end

    assign slot_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && slot_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && slot_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_frame_status  = r_out.frame_status;
    assign o_word_index    = r_out.word_index;
    assign o_word_value    = r_out.word_value;
    assign o_last_of_frame = r_out.last_of_frame;

    scfr_ctrl #(
        .FRAME_BYTES   (FRAME_BYTES),
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_res_valid   (res_valid),
        .i_res_ready   (slot_free),
        .o_res         (res),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (mem_rdata)
    );

    scfr_ram #(
        .DEPTH (FRAME_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/scfr_checker.sv
// Port-level checks for the sync frame receiver, bound to the top level.
// Uses scfr_pkg for the status codes.
`default_nettype none

module scfr_checker
    import scfr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_frame_status,
    input wire logic [3:0]  o_word_index,
    input wire logic [31:0] o_word_value,
    input wire logic        o_last_of_frame
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_word_value) &&
        $stable(o_word_index) && $stable(o_frame_status) && $stable(o_last_of_frame))
        else $error("result changed while stalled");

    // a reject is a single, empty result
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_status == STATUS_REJECT) |->
        o_last_of_frame && (o_word_index == 4'd0) && (o_word_value == 32'd0))
        else $error("malformed reject result");

    // more words of the frame follow, so no byte is taken meanwhile
    a_busy_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_frame |=> !o_in_ready)
        else $error("input taken in the middle of a frame's words");

    // words of one frame count up by one
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_frame ##1 o_out_valid |->
        o_word_index == $past(o_word_index) + 4'd1)
        else $error("word index skipped");

endmodule

bind sync_crc_frame_receiver scfr_checker u_scfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_frame_status  (o_frame_status),
    .o_word_index    (o_word_index),
    .o_word_value    (o_word_value),
    .o_last_of_frame (o_last_of_frame)
);

`default_nettype wire
